/* rtl/core/amci_pkg.sv */
// ----------------------------------------------------------------------------
// amci_pkg
// shared types and constants for the movi chunk indexer
// ----------------------------------------------------------------------------
package amci_pkg;

  localparam int unsigned OFS_W  = 63;  // absolute file offset width
  localparam int unsigned LEN_W  = 32;  // chunk size width
  localparam int unsigned STRM_W = 7;   // stream number width
  localparam int unsigned KIND_W = 2;   // chunk kind width
  localparam int unsigned SKIP_W = 33;  // payload plus pad byte count

  // ascii codes seen in chunk ids
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_W     = 8'h77;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // chunk kinds
  localparam logic [KIND_W-1:0] KIND_DB = 2'd0;  // uncompressed video
  localparam logic [KIND_W-1:0] KIND_DC = 2'd1;  // compressed video
  localparam logic [KIND_W-1:0] KIND_PC = 2'd2;  // palette change
  localparam logic [KIND_W-1:0] KIND_WB = 2'd3;  // audio

  typedef enum logic [1:0] {
    PH_HEADER   = 2'd0,
    PH_LISTTYPE = 2'd1,
    PH_SKIP     = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_beat_t;

  typedef struct packed {
    logic [OFS_W-1:0]  entry_offset;
    logic [LEN_W-1:0]  entry_length;
    logic [STRM_W-1:0] stream_number;
    logic [KIND_W-1:0] chunk_kind;
  } entry_t;

endpackage

/* rtl/core/amci_ifs.sv */
// ----------------------------------------------------------------------------
// amci channel interfaces
// valid/ready channels for bytes, index entries and the base offset register
// ----------------------------------------------------------------------------
interface amci_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface amci_entry_if;
  logic                            valid;
  logic                            ready;
  logic [amci_pkg::OFS_W-1:0]      entry_offset;
  logic [amci_pkg::LEN_W-1:0]      entry_length;
  logic [amci_pkg::STRM_W-1:0]     stream_number;
  logic [amci_pkg::KIND_W-1:0]     chunk_kind;

  modport source (output valid, output entry_offset, output entry_length,
                  output stream_number, output chunk_kind, input ready);
  modport sink   (input valid, input entry_offset, input entry_length,
                  input stream_number, input chunk_kind, output ready);
endinterface

interface amci_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [amci_pkg::OFS_W-1:0] list_base_offset;

  modport source (output valid, output list_base_offset, input ready);
  modport sink   (input valid, input list_base_offset, output ready);
endinterface

/* rtl/core/amci_in_stage.sv */
// ----------------------------------------------------------------------------
// amci_in_stage
// input register holding one byte beat until the parser takes it
// ----------------------------------------------------------------------------
module amci_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  amci_pkg::byte_beat_t in_beat,
  input  logic                 pop,
  output logic                 hold_valid,
  output amci_pkg::byte_beat_t hold_beat
);

  logic                 valid_r;
  logic                 valid_nxt;
  amci_pkg::byte_beat_t beat_r;
  logic                 take;

  assign in_ready   = !valid_r || pop;
  assign take       = in_valid && in_ready;
  assign hold_valid = valid_r;
  assign hold_beat  = beat_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      beat_r <= in_beat;
    end
  end

endmodule

/* rtl/core/amci_parser.sv */
// ----------------------------------------------------------------------------
// amci_parser
// chunk header state machine: assembles headers, descends lists, skips payload
// ----------------------------------------------------------------------------
module amci_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       beat_valid,
  input  amci_pkg::byte_beat_t       beat,
  input  logic                       out_free,
  input  logic                       cfg_we,
  input  logic [amci_pkg::OFS_W-1:0] cfg_base,
  output logic                       pop,
  output logic                       emit,
  output amci_pkg::entry_t           entry
);

  amci_pkg::phase_t                   phase_r, phase_nxt;
  logic [2:0]                         cnt_r, cnt_nxt;
  logic [31:0]                        id_r, id_nxt;
  logic [amci_pkg::LEN_W-1:0]         size_r, size_nxt;
  logic [amci_pkg::SKIP_W-1:0]        skip_r, skip_nxt;
  logic [amci_pkg::OFS_W-1:0]         pos_r, pos_nxt;
  logic [amci_pkg::OFS_W-1:0]         base_r, base_nxt;

  logic [31:0]                        id_upd;
  logic [amci_pkg::LEN_W-1:0]         size_upd;
  logic [amci_pkg::OFS_W-1:0]         payload;
  logic [7:0]                         c0, c1, c2, c3;
  logic                               hdr_done;
  logic                               is_list;
  logic                               digits_ok;
  logic                               kind_ok;
  logic [amci_pkg::KIND_W-1:0]        kind;
  logic                               emit_cand;
  logic [amci_pkg::SKIP_W-1:0]        skip_load;
  logic [amci_pkg::SKIP_W-1:0]        skip_dec;

  // header shifting and entry decode
  always_comb begin
    id_upd   = (!cnt_r[2]) ? {beat.data_byte, id_r[31:8]} : id_r;
    size_upd = (cnt_r[2]) ? {beat.data_byte, size_r[31:8]} : size_r;
    payload  = pos_r + {{(amci_pkg::OFS_W-1){1'b0}}, 1'b1};
    c0 = id_upd[7:0];
    c1 = id_upd[15:8];
    c2 = id_upd[23:16];
    c3 = id_upd[31:24];
    hdr_done  = (phase_r == amci_pkg::PH_HEADER) && (cnt_r == 3'd7);
    is_list   = (c0 == amci_pkg::CH_L) && (c1 == amci_pkg::CH_I) &&
                (c2 == amci_pkg::CH_S) && (c3 == amci_pkg::CH_T);
    digits_ok = (c0 >= amci_pkg::CH_ZERO) && (c0 <= amci_pkg::CH_NINE) &&
                (c1 >= amci_pkg::CH_ZERO) && (c1 <= amci_pkg::CH_NINE);
    kind_ok = 1'b1;
    kind    = amci_pkg::KIND_DB;
    if (c2 == amci_pkg::CH_D && c3 == amci_pkg::CH_B) begin
      kind = amci_pkg::KIND_DB;
    end else if (c2 == amci_pkg::CH_D && c3 == amci_pkg::CH_C) begin
      kind = amci_pkg::KIND_DC;
    end else if (c2 == amci_pkg::CH_P && c3 == amci_pkg::CH_C) begin
      kind = amci_pkg::KIND_PC;
    end else if (c2 == amci_pkg::CH_W && c3 == amci_pkg::CH_B) begin
      kind = amci_pkg::KIND_WB;
    end else begin
      kind_ok = 1'b0;
    end
    emit_cand = beat_valid && hdr_done && !is_list && digits_ok && kind_ok &&
                (size_upd != '0);
    // pad byte when the payload end lands on an odd offset
    skip_load = {1'b0, size_upd} +
                {{(amci_pkg::SKIP_W-1){1'b0}}, payload[0] ^ size_upd[0]};
    skip_dec  = (skip_r != '0) ? skip_r - {{(amci_pkg::SKIP_W-1){1'b0}}, 1'b1} : skip_r;

    entry.entry_offset  = payload;
    entry.entry_length  = size_upd;
    entry.stream_number = {c0[3:0], 3'b000} + {2'b00, c0[3:0], 1'b0} +
                          {3'b000, c1[3:0]};
    entry.chunk_kind    = kind;
  end

  // a beat with no result need not wait for the result register
  assign pop  = beat_valid && (out_free || !emit_cand);
  assign emit = pop && emit_cand;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    id_nxt    = id_r;
    size_nxt  = size_r;
    skip_nxt  = skip_r;
    pos_nxt   = pos_r;
    base_nxt  = base_r;
    if (pop) begin
      unique case (phase_r)
        amci_pkg::PH_HEADER: begin
          id_nxt   = id_upd;
          size_nxt = size_upd;
          cnt_nxt  = cnt_r + 3'd1;
          if (hdr_done) begin
            if (is_list) begin
              phase_nxt = amci_pkg::PH_LISTTYPE;
            end else begin
              skip_nxt  = skip_load;
              phase_nxt = (skip_load != '0) ? amci_pkg::PH_SKIP : amci_pkg::PH_HEADER;
            end
          end
        end
        amci_pkg::PH_LISTTYPE: begin
          if (cnt_r == 3'd3) begin
            cnt_nxt   = 3'd0;
            phase_nxt = amci_pkg::PH_HEADER;
          end else begin
            cnt_nxt = cnt_r + 3'd1;
          end
        end
        amci_pkg::PH_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == '0) begin
            phase_nxt = amci_pkg::PH_HEADER;
          end
        end
        default: begin
          phase_nxt = amci_pkg::PH_HEADER;
        end
      endcase
      pos_nxt = payload;
      if (beat.last_byte) begin
        phase_nxt = amci_pkg::PH_HEADER;
        cnt_nxt   = 3'd0;
        id_nxt    = '0;
        size_nxt  = '0;
        skip_nxt  = '0;
        pos_nxt   = base_r;
      end
    end
    if (cfg_we) begin
      base_nxt = cfg_base;
      pos_nxt  = cfg_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= amci_pkg::PH_HEADER;
      cnt_r   <= 3'd0;
      id_r    <= '0;
      size_r  <= '0;
      skip_r  <= '0;
      pos_r   <= '0;
      base_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      id_r    <= id_nxt;
      size_r  <= size_nxt;
      skip_r  <= skip_nxt;
      pos_r   <= pos_nxt;
      base_r  <= base_nxt;
    end
  end

endmodule

/* rtl/core/amci_out_stage.sv */
// ----------------------------------------------------------------------------
// amci_out_stage
// result register for one index entry
// ----------------------------------------------------------------------------
module amci_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  amci_pkg::entry_t load_entry,
  output logic             out_free,
  output logic             out_valid,
  input  logic             out_ready,
  output amci_pkg::entry_t out_entry
);

  logic             valid_r;
  logic             valid_nxt;
  amci_pkg::entry_t entry_r;

  assign out_free  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_entry = entry_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entry_r <= load_entry;
    end
  end

endmodule

/* rtl/core/avi_movi_chunk_indexer_top.sv */
// ----------------------------------------------------------------------------
// avi_movi_chunk_indexer_top
// scans movi list bytes and emits an index entry for each nonempty stream chunk
// ----------------------------------------------------------------------------
// path: the beat completing a header waits in the input register, and its
//   entry is then loaded into the result register once that register is free
// throughput: one byte beat per cycle while no stalled result holds the parser
// a stalled result only holds up bytes once the input register is also full
// reset: synchronous active-low rst_n clears both stage valids, the parse
//   state, the byte position and the base offset register
// ----------------------------------------------------------------------------
module avi_movi_chunk_indexer_top (
  input  logic          clk,
  input  logic          rst_n,
  amci_byte_if.sink     in_bus,
  amci_entry_if.source  out_bus,
  amci_cfg_if.sink      cfg_bus
);

  amci_pkg::byte_beat_t in_beat;
  amci_pkg::byte_beat_t hold_beat;
  amci_pkg::entry_t     parse_entry;
  amci_pkg::entry_t     out_entry;
  logic                 in_ready;
  logic                 hold_valid;
  logic                 pop;
  logic                 emit;
  logic                 out_free;
  logic                 out_valid;
  logic                 cfg_we;

  // base reg always ready; user must have writes arrive while idle, unenforced
  assign cfg_bus.ready = 1'b1;
  assign cfg_we        = cfg_bus.valid;

  assign in_beat.data_byte = in_bus.data_byte;
  assign in_beat.last_byte = in_bus.last_byte;
  assign in_bus.ready      = in_ready;

  // input register: decouples the byte source from a stalled result
  amci_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_bus.valid),
    .in_ready   (in_ready),
    .in_beat    (in_beat),
    .pop        (pop),
    .hold_valid (hold_valid),
    .hold_beat  (hold_beat)
  );

  // header assembly, list descent, payload skip and entry decode
  amci_parser u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_valid (hold_valid),
    .beat       (hold_beat),
    .out_free   (out_free),
    .cfg_we     (cfg_we),
    .cfg_base   (cfg_bus.list_base_offset),
    .pop        (pop),
    .emit       (emit),
    .entry      (parse_entry)
  );

  // result register for the index entry beat
  amci_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (emit),
    .load_entry (parse_entry),
    .out_free   (out_free),
    .out_valid  (out_valid),
    .out_ready  (out_bus.ready),
    .out_entry  (out_entry)
  );

  assign out_bus.valid         = out_valid;
  assign out_bus.entry_offset  = out_entry.entry_offset;
  assign out_bus.entry_length  = out_entry.entry_length;
  assign out_bus.stream_number = out_entry.stream_number;
  assign out_bus.chunk_kind    = out_entry.chunk_kind;

endmodule

/* test/amci_entry_scoreboard_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amci_entry_scoreboard_pkg
// predicts movi index entries from accepted byte beats and checks the results
// ----------------------------------------------------------------------------
package amci_entry_scoreboard_pkg;
  import amci_pkg::*;

  class entry_scoreboard;
    logic [OFS_W-1:0]  base_ofs;
    logic [OFS_W-1:0]  next_pos;
    phase_t            phase;
    int unsigned       hdr_cnt;
    logic [31:0]       id_bytes;
    logic [LEN_W-1:0]  size_bytes;
    logic [SKIP_W-1:0] skip_left;
    entry_t            expected_q[$];
    int unsigned       errors;
    int unsigned       entries_seen;

    function new();
      base_ofs     = '0;
      next_pos     = '0;
      errors       = 0;
      entries_seen = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      phase      = PH_HEADER;
      hdr_cnt    = 0;
      id_bytes   = '0;
      size_bytes = '0;
      skip_left  = '0;
    endfunction

    function int unsigned expected_count();
      return expected_q.size();
    endfunction

    function void set_base(logic [OFS_W-1:0] v);
      base_ofs = v;
      next_pos = v;
    endfunction

    function int tag_kind(logic [7:0] c2, logic [7:0] c3);
      if (c2 == CH_D && c3 == CH_B) return KIND_DB;
      if (c2 == CH_D && c3 == CH_C) return KIND_DC;
      if (c2 == CH_P && c3 == CH_C) return KIND_PC;
      if (c2 == CH_W && c3 == CH_B) return KIND_WB;
      return -1;
    endfunction

    function bit is_digit(logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // one accepted byte beat
    function void note_byte(logic [7:0] b, logic last);
      logic [OFS_W-1:0] pay_ofs;
      logic [7:0]       c0, c1, c2, c3;
      int               kind;
      entry_t           e;
      case (phase)
        PH_HEADER: begin
          if (hdr_cnt < 4) id_bytes = {b, id_bytes[31:8]};
          else size_bytes = {b, size_bytes[31:8]};
          hdr_cnt++;
          if (hdr_cnt == 8) begin
            pay_ofs = next_pos + 1'b1;
            c0 = id_bytes[7:0];
            c1 = id_bytes[15:8];
            c2 = id_bytes[23:16];
            c3 = id_bytes[31:24];
            hdr_cnt = 0;
            if (c0 == CH_L && c1 == CH_I && c2 == CH_S && c3 == CH_T) begin
              phase = PH_LISTTYPE;
            end else begin
              kind = tag_kind(c2, c3);
              if (is_digit(c0) && is_digit(c1) && kind >= 0 && size_bytes != 0) begin
                e.entry_offset  = pay_ofs;
                e.entry_length  = size_bytes;
                e.stream_number = STRM_W'((int'(c0) - int'(CH_ZERO)) * 10 +
                                          (int'(c1) - int'(CH_ZERO)));
                e.chunk_kind    = KIND_W'(kind);
                expected_q = {expected_q, e};
              end
              // pad byte when the payload ends on an odd offset
              skip_left = {1'b0, size_bytes} + SKIP_W'(pay_ofs[0] ^ size_bytes[0]);
              phase = (skip_left != 0) ? PH_SKIP : PH_HEADER;
            end
          end
        end
        PH_LISTTYPE: begin
          hdr_cnt++;
          if (hdr_cnt == 4) begin
            hdr_cnt = 0;
            phase   = PH_HEADER;
          end
        end
        default: begin
          if (skip_left != 0) skip_left--;
          if (skip_left == 0) phase = PH_HEADER;
        end
      endcase
      next_pos = next_pos + 1'b1;
      if (last) begin
        clear_parse();
        next_pos = base_ofs;
      end
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_entry(entry_t got);
      entry_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("entry with none pending: ofs %h len %h strm %0d kind %0d",
                         got.entry_offset, got.entry_length, got.stream_number,
                         got.chunk_kind));
        return;
      end
      want = expected_q.pop_front();
      entries_seen++;
      if (got.entry_offset !== want.entry_offset)
        report($sformatf("entry_offset got %h want %h", got.entry_offset,
                         want.entry_offset));
      if (got.entry_length !== want.entry_length)
        report($sformatf("entry_length got %h want %h", got.entry_length,
                         want.entry_length));
      if (got.stream_number !== want.stream_number)
        report($sformatf("stream_number got %0d want %0d", got.stream_number,
                         want.stream_number));
      if (got.chunk_kind !== want.chunk_kind)
        report($sformatf("chunk_kind got %0d want %0d", got.chunk_kind,
                         want.chunk_kind));
    endtask
  endclass

endpackage

/* test/avi_movi_chunk_indexer_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avi_movi_chunk_indexer_top_tb
// feeds movi list byte streams built from stream chunks, LIST headers, odd ids
// and noise, under random base offsets and random gaps on both channels, and
// checks every index entry against a cycle-free prediction of the parser
// ----------------------------------------------------------------------------
module avi_movi_chunk_indexer_top_tb;
  import amci_pkg::*;
  import amci_entry_scoreboard_pkg::*;

  localparam int unsigned    BYTE_TARGET = 1100;
  localparam int unsigned    CYCLE_LIMIT = 400000;
  localparam logic [OFS_W-1:0] OFS_MAX   = {OFS_W{1'b1}};

  logic clk;
  logic rst_n;

  amci_byte_if  in_bus ();
  amci_entry_if out_bus ();
  amci_cfg_if   cfg_bus ();

  avi_movi_chunk_indexer_top i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  entry_scoreboard  sb;
  logic [7:0]       list_q[$];      // bytes of the list being built
  logic [OFS_W-1:0] cur_base;       // base offset as last programmed
  bit               in_idle_on;     // sender gaps enabled for this list
  int unsigned      bytes_sent;
  int unsigned      lists_sent;
  int unsigned      cfg_writes;
  int unsigned      cycle_cnt;

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run guard, counted in rising edges
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d entries still pending", cycle_cnt,
               sb.expected_count());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int unsigned draw_gap(bit on);
    return on ? $urandom_range(0, 11) : 0;
  endfunction

  // ---------------------------------------------------------------------------
  // list building: every chunk is appended to list_q
  // ---------------------------------------------------------------------------
  function automatic void put_byte(logic [7:0] b);
    list_q = {list_q, b};
  endfunction

  function automatic void put_word(logic [31:0] w);
    put_byte(w[7:0]);
    put_byte(w[15:8]);
    put_byte(w[23:16]);
    put_byte(w[31:24]);
  endfunction

  // header, npay payload bytes, and the pad byte if the payload is complete and
  // ends on an odd absolute offset
  function automatic void put_chunk(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2,
                                    logic [7:0] c3, logic [31:0] size,
                                    int unsigned npay);
    int unsigned pay_idx;
    bit          end_odd;
    put_word({c3, c2, c1, c0});
    put_word(size);
    pay_idx = list_q.size();
    end_odd = cur_base[0] ^ pay_idx[0] ^ size[0];
    for (int unsigned i = 0; i < npay; i++) put_byte(8'($urandom));
    if (npay == size && end_odd) put_byte(8'($urandom));
  endfunction

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // the two tag letters of one of the four stream chunk kinds
  function automatic logic [15:0] rand_tag();
    case ($urandom_range(0, 3))
      0:       return {CH_D, CH_B};
      1:       return {CH_D, CH_C};
      2:       return {CH_P, CH_C};
      default: return {CH_W, CH_B};
    endcase
  endfunction

  function automatic logic [31:0] rand_small_size();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'($urandom_range(13, 40));
      default: return 32'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [OFS_W-1:0] pick_base();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return OFS_MAX;
      2:       return OFS_MAX - OFS_W'($urandom_range(0, 40));
      3:       return OFS_W'({$urandom, $urandom});
      4:       return OFS_W'($urandom_range(0, 1000));
      default: return OFS_W'(1);
    endcase
  endfunction

  // mostly well-formed chunk sequences, with some broken headers and noise
  function automatic void build_random_list();
    int unsigned nchunk;
    int unsigned sel;
    logic [15:0] tag;
    logic [31:0] size;
    bit          ended;
    list_q.delete();
    nchunk = $urandom_range(1, 8);
    ended  = 1'b0;
    for (int unsigned k = 0; k < nchunk && !ended; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        // stream chunk with full payload
        tag  = rand_tag();
        size = rand_small_size();
        put_chunk(rand_digit(), rand_digit(), tag[15:8], tag[7:0], size, size);
      end else if (sel < 70) begin
        // nested list: size ignored, type consumed
        put_word({CH_T, CH_S, CH_I, CH_L});
        put_word($urandom);
        if ($urandom_range(0, 1)) put_word(32'h20636572);
        else put_word($urandom);
      end else if (sel < 80) begin
        // near-miss ids are skipped like any other chunk
        size = rand_small_size();
        case ($urandom_range(0, 4))
          0: put_chunk(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                       size, size);
          1: put_chunk(rand_digit(), rand_digit(), CH_D, CH_W, size, size);
          2: put_chunk(CH_ZERO - 8'd1, rand_digit(), CH_W, CH_B, size, size);
          3: put_chunk(rand_digit(), CH_NINE + 8'd1, CH_D, CH_C, size, size);
          default: put_chunk(CH_L, CH_I, CH_S, CH_B, size, size);
        endcase
      end else if (sel < 88) begin
        // noise that throws the header alignment off
        repeat ($urandom_range(1, 6)) put_byte(8'($urandom));
      end else begin
        // huge payload that runs past the end of the list
        tag  = rand_tag();
        size = $urandom | 32'h0000_0100;
        if ($urandom_range(0, 3) == 0) size = 32'hFFFF_FFFF;
        put_chunk(rand_digit(), rand_digit(), tag[15:8], tag[7:0], size,
                  $urandom_range(0, 3));
        ended = 1'b1;
      end
    end
    // partial trailing header now and then
    if (!ended && $urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 7)) put_byte(8'($urandom));
  endfunction

  // ---------------------------------------------------------------------------
  // drivers; each task starts and ends at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b, logic last);
    int unsigned gap;
    gap = draw_gap(in_idle_on);
    repeat (gap) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid     = 1'b1;
    in_bus.data_byte = b;
    in_bus.last_byte = last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sb.note_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_list();
    for (int unsigned i = 0; i < list_q.size(); i++)
      send_byte(list_q[i], i == list_q.size() - 1);
    lists_sent++;
  endtask

  // base offset is only written with the parser drained
  task automatic program_base(logic [OFS_W-1:0] v);
    in_bus.valid = 1'b0;
    while (sb.expected_count() != 0) @(negedge clk);
    // a beat with no entry may still be in flight
    repeat (8) @(negedge clk);
    cfg_bus.valid            = 1'b1;
    cfg_bus.list_base_offset = v;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    sb.set_base(v);
    cur_base = v;
    cfg_writes++;
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls per entry, stall-free stretches every so often
  // ---------------------------------------------------------------------------
  initial begin : entry_sink
    entry_t      got;
    int unsigned gap;
    int unsigned n_taken;
    bit          stall_on;
    out_bus.ready = 1'b0;
    n_taken  = 0;
    stall_on = 1'b1;
    @(negedge clk);
    forever begin
      gap = draw_gap(stall_on);
      repeat (gap) begin
        out_bus.ready = 1'b0;
        @(negedge clk);
      end
      out_bus.ready = 1'b1;
      @(posedge clk);
      while (!out_bus.valid) @(posedge clk);
      got.entry_offset  = out_bus.entry_offset;
      got.entry_length  = out_bus.entry_length;
      got.stream_number = out_bus.stream_number;
      got.chunk_kind    = out_bus.chunk_kind;
      sb.check_entry(got);
      n_taken++;
      // redraw the stall mode every 20 entries
      if (n_taken % 20 == 0) stall_on = ($urandom_range(0, 2) != 0);
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    sb         = new();
    cycle_cnt  = 0;
    bytes_sent = 0;
    lists_sent = 0;
    cfg_writes = 0;
    cur_base   = '0;
    in_idle_on = 1'b0;
    rst_n                    = 1'b0;
    in_bus.valid             = 1'b0;
    in_bus.data_byte         = 8'h00;
    in_bus.last_byte         = 1'b0;
    cfg_bus.valid            = 1'b0;
    cfg_bus.list_base_offset = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // directed: base near the top so payload offsets wrap past zero;
    // audio chunk with pad, zero-size chunk with no skip, and a palette
    // header of maximum size completed by the last beat of the list
    program_base(OFS_MAX - OFS_W'(5));
    list_q.delete();
    put_chunk(CH_NINE, CH_NINE, CH_W, CH_B, 32'd1, 1);
    put_chunk(CH_ZERO, CH_ZERO, CH_D, CH_B, 32'd0, 0);
    put_chunk(CH_ZERO, CH_ZERO + 8'd7, CH_P, CH_C, 32'hFFFF_FFFF, 0);
    send_list();

    // directed: base zero, nested list, then a compressed video chunk whose
    // skip is cut short by the end of the list
    program_base('0);
    list_q.delete();
    put_word({CH_T, CH_S, CH_I, CH_L});
    put_word(32'd0);
    put_word(32'h20636572);
    put_chunk(CH_ZERO + 8'd4, CH_ZERO + 8'd2, CH_D, CH_C, 32'd3, 2);
    send_list();

    // random lists, with the base reprogrammed between some of them
    while (bytes_sent < BYTE_TARGET) begin
      if ($urandom_range(0, 2) == 0) program_base(pick_base());
      in_idle_on = ($urandom_range(0, 3) != 0);
      build_random_list();
      send_list();
    end
    in_bus.valid = 1'b0;

    // drain, then allow for pipeline latency
    while (sb.expected_count() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("covered %0d byte beats in %0d lists, %0d base offset writes",
             bytes_sent, lists_sent, cfg_writes);
    $display("checked %0d index entries in %0d cycles, %0d mismatches",
             sb.entries_seen, cycle_cnt, sb.errors);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* avi_movi_chunk_indexer_top.f */
rtl/core/amci_pkg.sv
rtl/core/amci_ifs.sv
rtl/core/amci_in_stage.sv
rtl/core/amci_parser.sv
rtl/core/amci_out_stage.sv
rtl/core/avi_movi_chunk_indexer_top.sv
test/amci_entry_scoreboard_pkg.sv
test/avi_movi_chunk_indexer_top_tb.sv
